[hw/rtl/xmbr_pkg.sv]
// Shared types and constants for the XMODEM block receiver.
// Holds the control-byte codes, mode/state/event encodings and the result struct.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package xmbr_pkg;

	// protocol control bytes
	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] EOT_BYTE = 8'h04;
	localparam logic [7:0] ACK_BYTE = 8'h06;
	localparam logic [7:0] NAK_BYTE = 8'h15;
	localparam logic [7:0] CAN_BYTE = 8'h18;

	// frame layout: SOH, number, complement, 128 payload bytes, checksum
	localparam logic [7:0] POS_PAYLOAD_FIRST = 8'd3;
	localparam logic [7:0] POS_CHECKSUM      = 8'd131;
	localparam logic [7:0] POS_SATURATE      = 8'd255;
	localparam logic [8:0] HDR_PAIR_SUM      = 9'h0ff;
	localparam logic [7:0] BLOCK_RESYNC      = 8'd1;

	// configuration register indexes and reset values
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRIES = 2'd1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
	localparam logic [3:0]  RETRIES_RESET = 4'd3;

	typedef enum logic [1:0] {
		MODE_BYTE  = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_START = 2'd2,
		MODE_STOP  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE       = 2'd0,
		ST_WAIT_START = 2'd1,
		ST_WAIT_DATA  = 2'd2
	} sess_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_ACCEPT = 2'd1,
		EV_END    = 2'd2,
		EV_REJECT = 2'd3
	} ev_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [3:0]  max_retries;
	} cfg_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [6:0] payload_index;
		ev_t        event_res;
		logic [7:0] block_number;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/xmbr_proto.sv]
// Protocol engine of the XMODEM block receiver: session state, frame assembly,
// checksum, timeout and the reply/payload decision for one item per step.
// Depends on xmbr_pkg.
`default_nettype none

module xmbr_proto (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               step,
	input  xmbr_pkg::mode_t   mode,
	input  wire [7:0]         frame_byte,
	input  wire               frame_last,
	input  xmbr_pkg::cfg_t    cfg,
	output logic              res_valid,
	output xmbr_pkg::result_t res
);
	import xmbr_pkg::*;

	sess_t       st_q, st_d;
	logic [7:0]  exp_q, exp_d;
	logic [3:0]  retry_q, retry_d;
	logic [15:0] ticks_q, ticks_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  hdr_q, hdr_d;
	logic        hok_q, hok_d;
	logic [7:0]  pay_idx;

	assign pay_idx = pos_q - POS_PAYLOAD_FIRST;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			exp_q   <= '0;
			retry_q <= '0;
			ticks_q <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
			first_q <= '0;
			hdr_q   <= '0;
			hok_q   <= 1'b0;
		end else if (step) begin
			st_q    <= st_d;
			exp_q   <= exp_d;
			retry_q <= retry_d;
			ticks_q <= ticks_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			first_q <= first_d;
			hdr_q   <= hdr_d;
			hok_q   <= hok_d;
		end
	end

	// next state and result for the current item
	always_comb begin
		st_d      = st_q;
		exp_d     = exp_q;
		retry_d   = retry_q;
		ticks_d   = ticks_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		first_d   = first_q;
		hdr_d     = hdr_q;
		hok_d     = hok_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (mode)
			MODE_BYTE: begin
				if (st_q == ST_IDLE) begin
					pos_d   = '0;
					sum_d   = '0;
					first_d = '0;
					hdr_d   = '0;
					hok_d   = 1'b0;
				end else if (frame_last) begin
					ticks_d   = '0;
					res_valid = 1'b1;
					res.send_valid = 1'b1;
					if (pos_q == '0 && frame_byte == EOT_BYTE) begin
						// end of transmission
						st_d          = ST_IDLE;
						res.send_byte = ACK_BYTE;
						res.event_res = EV_END;
					end else if (pos_q != POS_CHECKSUM || !hok_q || sum_q != frame_byte) begin
						res.send_byte = NAK_BYTE;
						res.event_res = EV_REJECT;
					end else if (hdr_q == exp_q
							|| (hdr_q == BLOCK_RESYNC && exp_q != BLOCK_RESYNC)) begin
						// expected block, or block one resyncs the sequence
						if (hdr_q == BLOCK_RESYNC && exp_q != BLOCK_RESYNC) begin
							st_d = ST_WAIT_DATA;
						end
						exp_d            = hdr_q + 8'd1;
						res.send_byte    = ACK_BYTE;
						res.event_res    = EV_ACCEPT;
						res.block_number = hdr_q;
					end else begin
						st_d          = ST_IDLE;
						res.send_byte = CAN_BYTE;
						res.event_res = EV_END;
					end
					pos_d   = '0;
					sum_d   = '0;
					first_d = '0;
					hdr_d   = '0;
					hok_d   = 1'b0;
				end else begin
					ticks_d = '0;
					// header capture
					if (pos_q == 8'd0) begin
						first_d = frame_byte;
					end else if (pos_q == 8'd1) begin
						hdr_d = frame_byte;
					end else if (pos_q == 8'd2) begin
						hok_d = (first_q == SOH_BYTE)
							&& ({1'b0, hdr_q} + {1'b0, frame_byte} == HDR_PAIR_SUM);
					end
					if (pos_q < POS_CHECKSUM) begin
						sum_d = sum_q + frame_byte;
					end
					// tentative payload byte
					if (pos_q >= POS_PAYLOAD_FIRST && pos_q < POS_CHECKSUM) begin
						res_valid         = 1'b1;
						res.payload_valid = 1'b1;
						res.payload_byte  = frame_byte;
						res.payload_index = pay_idx[6:0];
					end
					if (pos_q != POS_SATURATE) begin
						pos_d = pos_q + 8'd1;
					end
				end
			end
			MODE_TICK: begin
				if (st_q != ST_IDLE) begin
					if (ticks_q < cfg.timeout_ticks) begin
						ticks_d = ticks_q + 16'd1;
					end else begin
						ticks_d   = '0;
						res_valid = 1'b1;
						if (st_q == ST_WAIT_START && retry_q < cfg.max_retries) begin
							retry_d        = retry_q + 4'd1;
							res.send_valid = 1'b1;
							res.send_byte  = NAK_BYTE;
						end else begin
							retry_d       = '0;
							st_d          = ST_IDLE;
							pos_d         = '0;
							sum_d         = '0;
							first_d       = '0;
							hdr_d         = '0;
							hok_d         = 1'b0;
							res.event_res = EV_END;
						end
					end
				end
			end
			MODE_START: begin
				st_d           = ST_WAIT_START;
				ticks_d        = '0;
				pos_d          = '0;
				sum_d          = '0;
				first_d        = '0;
				hdr_d          = '0;
				hok_d          = 1'b0;
				res_valid      = 1'b1;
				res.send_valid = 1'b1;
				res.send_byte  = NAK_BYTE;
			end
			MODE_STOP: begin
				st_d           = ST_IDLE;
				pos_d          = '0;
				sum_d          = '0;
				first_d        = '0;
				hdr_d          = '0;
				hok_d          = 1'b0;
				res_valid      = 1'b1;
				res.send_valid = 1'b1;
				res.send_byte  = CAN_BYTE;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// frame assembly is always empty outside a session
	a_idle_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> pos_q == '0 && !hok_q)
		else $error("frame assembly not cleared while idle");

	// header check is only ever set once the header bytes are in
	a_hok_pos: assert property (@(posedge clk) disable iff (!arst_n)
		hok_q |-> pos_q >= POS_PAYLOAD_FIRST)
		else $error("header flag set before header complete");

	// payload results carry no reply and no event
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.payload_valid |-> !res.send_valid && res.event_res == EV_NONE)
		else $error("payload result mixed with reply or event");

endmodule

`default_nettype wire

[hw/rtl/xmodem_block_receiver_top.sv]
// Top level of the XMODEM block receiver: stream ports, input and result registers,
// configuration registers. Depends on xmbr_pkg and xmbr_proto.
//
// Channel | Direction | Handshake          | Contents
// s_*     | in        | s_tvalid/s_tready  | frame byte, mode in tuser, frame end in tlast
// m_*     | out       | m_tvalid/m_tready  | reply byte, payload byte/index, event, block number
// cfg_*   | in        | cfg_valid/cfg_ready| register index and write data
//
// One item per cycle sustained while m_tready is high; each item is held in the input
// register, and its result is loaded into the result register, from which it is taken.
// With the input register empty one new item is taken while a finished result waits; then
// s_tready drops. A stall on m_tready holds the result and the item behind it.
// Asynchronous reset returns to idle with timeout 3000 ticks and 3 retries; no clearing pass.
// cfg_ready is always high.
`default_nettype none

module xmodem_block_receiver_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [7:0]                       s_tdata,  // [7:0] frame_byte
	input  wire  [1:0]                       s_tuser,  // [1:0] mode
	input  wire                              s_tlast,  // frame_last
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [31:0]                      m_tdata,  // [7:0] send_byte, [15:8] payload_byte,
	                                                    // [22:16] payload_index,
	                                                    // [30:23] block_number, [31] zero
	output logic [3:0]                       m_tuser,  // [0] send_valid, [1] payload_valid,
	                                                    // [3:2] event_res
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [xmbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [15:0]                      cfg_data
);
	import xmbr_pkg::*;

	logic       valid_s1;
	mode_t      mode_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       step;
	logic       core_valid;
	result_t    core_res;
	logic       m_valid_q;
	result_t    res_q;
	cfg_t       cfg_q;

	assign step      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || step;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
			cfg_q.max_retries   <= RETRIES_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				CFG_RETRIES: cfg_q.max_retries   <= cfg_data[3:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= mode_t'(s_tuser);
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	xmbr_proto u_proto (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.mode       (mode_s1),
		.frame_byte (byte_s1),
		.frame_last (last_s1),
		.cfg        (cfg_q),
		.res_valid  (core_valid),
		.res        (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= core_valid;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= core_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, res_q.block_number, res_q.payload_index,
		res_q.payload_byte, res_q.send_byte};
	assign m_tuser  = {res_q.event_res, res_q.payload_valid, res_q.send_valid};

	// an item waiting behind a stalled result is not dropped
	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_valid_q && !m_tready |=> valid_s1)
		else $error("queued item lost during output stall");

	// the engine only advances when the result slot is free
	a_step_slot: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !m_valid_q || m_tready)
		else $error("step while result register occupied");

	// a stalled output transaction keeps its contents
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

endmodule

`default_nettype wire
